>>> rtl/dqsb_pkg.sv
// ----------------------------------------------------------------------------
// dqsb_pkg
// Shared types and constants for the dual queue shared buffer block.
// ----------------------------------------------------------------------------
package dqsb_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;

  // address of one buffer entry
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // signed pointer that holds -1 .. DEPTH
  localparam int unsigned PTR_W = $clog2(DEPTH + 1) + 1;

  typedef logic signed [PTR_W-1:0] ptr_t;
  typedef logic [AW-1:0]           addr_t;
  typedef logic [DATA_WIDTH-1:0]   word_t;

  localparam ptr_t PTR_ONE     = ptr_t'(1);
  localparam ptr_t PTR_EMPTY_A = ptr_t'(-1);
  localparam ptr_t PTR_EMPTY_B = ptr_t'(DEPTH);
  localparam ptr_t PTR_TOP     = ptr_t'(DEPTH - 1);
  localparam ptr_t PTR_ZERO    = ptr_t'(0);

  typedef enum logic [1:0] {
    CMD_ENQ_A = 2'd0,
    CMD_DEQ_A = 2'd1,
    CMD_ENQ_B = 2'd2,
    CMD_DEQ_B = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic latch;  // capture the incoming command
    logic exec;   // update pointers and access the buffer
  } ctrl_cmd_t;

endpackage

>>> rtl/dqsb_ctrl.sv
// ----------------------------------------------------------------------------
// dqsb_ctrl
// Sequencer: accept a command, execute it, then offer the result.
// ----------------------------------------------------------------------------
module dqsb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dqsb_pkg::ctrl_cmd_t cmd_o
);
  import dqsb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_RESP;
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign cmd_o.latch = in_ready_o && in_valid_i;
  assign cmd_o.exec  = (state_q == S_EXEC);

endmodule

>>> rtl/dqsb_datapath.sv
// ----------------------------------------------------------------------------
// dqsb_datapath
// Queue pointers, shared buffer and result registers.
// ----------------------------------------------------------------------------
module dqsb_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dqsb_pkg::ctrl_cmd_t cmd_i,
  input  logic [1:0]          in_cmd_i,
  input  logic [31:0]         in_value_i,
  output logic [1:0]          out_status_o,
  output logic [31:0]         out_data_o
);
  import dqsb_pkg::*;

  word_t mem [DEPTH];

  logic [1:0]  cmd_q;
  logic [31:0] value_q;
  ptr_t        head_a_q, head_a_d, tail_a_q, tail_a_d;
  ptr_t        head_b_q, head_b_d, tail_b_q, tail_b_d;
  status_e     status_q, status_d;
  logic        rd_ok_q;
  word_t       rdata_q;

  logic  wr_en, rd_en;
  ptr_t  wr_ptr, rd_ptr;
  word_t wr_word;

  assign wr_word = DATA_WIDTH'($unsigned(value_q));

  always_comb begin
    head_a_d = head_a_q;
    tail_a_d = tail_a_q;
    head_b_d = head_b_q;
    tail_b_d = tail_b_q;
    status_d = ST_OK;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_ptr   = PTR_ZERO;
    rd_ptr   = PTR_ZERO;
    case (cmd_e'(cmd_q))
      CMD_ENQ_A: begin
        if (tail_a_q + PTR_ONE >= tail_b_q) begin
          status_d = ST_OVERFLOW;
        end else begin
          // an empty queue has tail -1, so the next entry is 0 either way
          wr_en    = 1'b1;
          wr_ptr   = tail_a_q + PTR_ONE;
          tail_a_d = tail_a_q + PTR_ONE;
          if (head_a_q == PTR_EMPTY_A) head_a_d = PTR_ZERO;
        end
      end
      CMD_DEQ_A: begin
        if (head_a_q == PTR_EMPTY_A) begin
          status_d = ST_UNDERFLOW;
        end else begin
          rd_en    = 1'b1;
          rd_ptr   = head_a_q;
          head_a_d = head_a_q + PTR_ONE;
          if (head_a_q + PTR_ONE > tail_a_q) begin
            head_a_d = PTR_EMPTY_A;
            tail_a_d = PTR_EMPTY_A;
          end
        end
      end
      CMD_ENQ_B: begin
        if (tail_b_q - PTR_ONE <= tail_a_q) begin
          status_d = ST_OVERFLOW;
        end else begin
          wr_en    = 1'b1;
          wr_ptr   = tail_b_q - PTR_ONE;
          tail_b_d = tail_b_q - PTR_ONE;
          if (head_b_q == PTR_EMPTY_B) head_b_d = PTR_TOP;
        end
      end
      CMD_DEQ_B: begin
        if (head_b_q == PTR_EMPTY_B) begin
          status_d = ST_UNDERFLOW;
        end else begin
          rd_en    = 1'b1;
          rd_ptr   = head_b_q;
          head_b_d = head_b_q - PTR_ONE;
          if (head_b_q - PTR_ONE < tail_b_q) begin
            head_b_d = PTR_EMPTY_B;
            tail_b_d = PTR_EMPTY_B;
          end
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q   <= in_cmd_i;
      value_q <= in_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_a_q <= PTR_EMPTY_A;
      tail_a_q <= PTR_EMPTY_A;
      head_b_q <= PTR_EMPTY_B;
      tail_b_q <= PTR_EMPTY_B;
    end else if (cmd_i.exec) begin
      head_a_q <= head_a_d;
      tail_a_q <= tail_a_d;
      head_b_q <= head_b_d;
      tail_b_q <= tail_b_d;
    end
  end

  // result registers hold until the next command executes
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      rd_ok_q  <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[wr_ptr[AW-1:0]] <= wr_word;
    end
    if (cmd_i.exec && rd_en) begin
      rdata_q <= mem[rd_ptr[AW-1:0]];
    end
  end

  assign out_status_o = status_q;
  assign out_data_o   = rd_ok_q ? 32'(rdata_q) : 32'd0;

endmodule

>>> rtl/dual_queue_shared_buffer_core.sv
// ----------------------------------------------------------------------------
// dual_queue_shared_buffer_core
// Two queues in one shared buffer: A grows up from entry 0, B down from the top.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one command per transfer: tuser carries the command
//   (enqueue A, dequeue A, enqueue B, dequeue B), tdata the word to enqueue.
//   Master stream returns exactly one result per command: tuser carries the
//   status (ok, overflow, underflow), tdata the dequeued word, zero otherwise.
//   Steps: the command is registered, the execute step updates the pointers
//   and does the registered buffer read, and the result is then offered;
//   the block works on one command at a time and takes no new command
//   while one is in flight.
//   A receiver stall holds the result, and s_axis_tready stays low until the
//   result transfer completes.
//   Reset empties both queues at once; buffer contents are not cleared and
//   only entries already written are ever read back.
//   An enqueue is refused when the two tails would meet. Space freed at the
//   front of a queue is reused only once that queue drains.
// ----------------------------------------------------------------------------
module dual_queue_shared_buffer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] data
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import dqsb_pkg::*;

  ctrl_cmd_t ctrl_cmd;

  dqsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (ctrl_cmd)
  );

  dqsb_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .in_cmd_i     (s_axis_tuser),
    .in_value_i   (s_axis_tdata),
    .out_status_o (m_axis_tuser),
    .out_data_o   (m_axis_tdata)
  );

endmodule

>>> rtl/dqsb_checker.sv
// ----------------------------------------------------------------------------
// dqsb_checker
// Port-level checks of the dual queue shared buffer core, bound to the top.
// ----------------------------------------------------------------------------
module dqsb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import dqsb_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // no result during the transfer or the execute step; the result follows the execute step
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid ##1 !m_axis_tvalid ##1 m_axis_tvalid)
    else $error("result latency wrong");

  // one command in flight: no new transfer while a result waits
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("command accepted while result pending");

  // a failed command returns zero data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == 32'd0))
    else $error("failed command returned data");

  // a status code outside the defined three never appears
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_OVERFLOW) ||
      (m_axis_tuser == ST_UNDERFLOW))
    else $error("undefined status code");

endmodule

bind dual_queue_shared_buffer_core dqsb_checker u_dqsb_checker (.*);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dual_queue_shared_buffer_core: drives enqueue and
// dequeue commands on the slave stream, mirrors both queue pointers and the
// shared buffer, and compares every result transfer against the mirror.
// ----------------------------------------------------------------------------
module testbench;
  import dqsb_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;

  typedef struct packed {
    status_e status;
    word_t   data;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  // mirror of the block state
  word_t   word_mirror [DEPTH];
  ptr_t    a_head, a_tail, b_head, b_tail;
  result_t pending_results [$];

  int unsigned err_cnt;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          src_idle_en;
  bit          snk_idle_en;

  dual_queue_shared_buffer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic result_t predict_result(cmd_e cmd, word_t value);
    result_t r;
    r.status = ST_OK;
    r.data   = '0;
    case (cmd)
      CMD_ENQ_A: begin
        if (a_tail + PTR_ONE >= b_tail) begin
          r.status = ST_OVERFLOW;
        end else begin
          if (a_head == PTR_EMPTY_A) begin
            a_head = PTR_ZERO;
            a_tail = PTR_ZERO;
          end else begin
            a_tail = a_tail + PTR_ONE;
          end
          word_mirror[addr_t'(a_tail)] = value;
        end
      end
      CMD_DEQ_A: begin
        if (a_head == PTR_EMPTY_A) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.data = word_mirror[addr_t'(a_head)];
          a_head = a_head + PTR_ONE;
          // drained: back to the empty position
          if (a_head > a_tail) begin
            a_head = PTR_EMPTY_A;
            a_tail = PTR_EMPTY_A;
          end
        end
      end
      CMD_ENQ_B: begin
        if (b_tail - PTR_ONE <= a_tail) begin
          r.status = ST_OVERFLOW;
        end else begin
          if (b_head == PTR_EMPTY_B) begin
            b_head = PTR_TOP;
            b_tail = PTR_TOP;
          end else begin
            b_tail = b_tail - PTR_ONE;
          end
          word_mirror[addr_t'(b_tail)] = value;
        end
      end
      default: begin
        if (b_head == PTR_EMPTY_B) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.data = word_mirror[addr_t'(b_head)];
          b_head = b_head - PTR_ONE;
          if (b_head < b_tail) begin
            b_head = PTR_EMPTY_B;
            b_tail = PTR_EMPTY_B;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %h want %h", $time, what, got, want);
    err_cnt++;
  endtask

  // Offer one command and hold it until the transfer completes.
  task automatic send_cmd(input cmd_e cmd, input word_t value);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= value;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    pending_results.push_back(predict_result(cmd, value));
  endtask

  // Stop offering and wait until every outstanding result has arrived.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic send_random_cmd(input int unsigned fill_pct);
    bit enq;
    bit to_b;
    enq  = ($urandom_range(0, 99) < fill_pct);
    to_b = 1'($urandom_range(0, 1));
    if (to_b) send_cmd(enq ? CMD_ENQ_B : CMD_DEQ_B, pick_word());
    else      send_cmd(enq ? CMD_ENQ_A : CMD_DEQ_A, pick_word());
  endtask

  task automatic test_empty_dequeue();
    send_cmd(CMD_DEQ_A, 32'hffff_ffff);
    send_cmd(CMD_DEQ_B, 32'h8000_0000);
  endtask

  // Fill the buffer from both ends until the tails meet, then overflow both.
  task automatic test_fill_to_meet();
    word_t edge_words [6];
    edge_words = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
                   32'h7fff_ffff, 32'h5555_5555, 32'haaaa_aaaa};
    for (int i = 0; i < 10; i++)
      send_cmd(CMD_ENQ_A, (i < 6) ? edge_words[i] : word_t'($urandom()));
    for (int i = 0; i < 6; i++)
      send_cmd(CMD_ENQ_B, edge_words[5 - i]);
    send_cmd(CMD_ENQ_A, 32'h1234_5678);
    send_cmd(CMD_ENQ_B, 32'h8765_4321);
  endtask

  // Hold the receiver off so the block stalls its input, then drain.
  task automatic test_backpressure();
    hold_left = 80;
    for (int i = 0; i < 6; i++) send_random_cmd(50);
    wait_drained();
  endtask

  // Phases biased towards filling, draining or neither, so the queues
  // repeatedly meet and empty.
  task automatic test_queue_traffic(input int unsigned n_items);
    int unsigned phase_left;
    int unsigned fill_pct;
    phase_left = 0;
    fill_pct   = 50;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0:       fill_pct = 80;
          1:       fill_pct = 20;
          default: fill_pct = 50;
        endcase
        phase_left = $urandom_range(8, 40);
      end
      phase_left--;
      send_random_cmd(fill_pct);
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
  endtask

  task automatic test_streaming(input int unsigned n_items);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    test_queue_traffic(n_items);
  endtask

  // receiver: random stall bursts plus an occasional long hold-off
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status)
          report_mismatch("status", 32'(m_tuser), 32'(want.status));
        if (m_tdata !== want.data)   report_mismatch("data", m_tdata, want.data);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("dual_queue_shared_buffer_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    err_cnt      = 0;
    quiet_cycles = 0;
    hold_left    = 0;
    src_idle_en  = 1'b1;
    snk_idle_en  = 1'b1;
    rst_ni       = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = CMD_ENQ_A;
    m_tready     = 1'b0;
    a_head       = PTR_EMPTY_A;
    a_tail       = PTR_EMPTY_A;
    b_head       = PTR_EMPTY_B;
    b_tail       = PTR_EMPTY_B;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_dequeue();
    test_fill_to_meet();
    test_backpressure();
    test_queue_traffic(1000);
    test_streaming(320);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("dual_queue_shared_buffer_core: match");
    end else begin
      $display("dual_queue_shared_buffer_core: mismatch");
    end
    $finish;
  end

endmodule
